>>> sv/kfr_pkg.sv
// Shared constants, codes and controller/datapath command and status types.
`timescale 1ns / 1ps
`default_nettype none
package kfr_pkg;

    localparam int SLOTS_DEFAULT   = 32;
    localparam int VIEWERS_DEFAULT = 4;

    localparam int MODE_W   = 2;
    localparam int BYTES_W  = 32;
    localparam int VIEWER_W = 2;
    localparam int STATUS_W = 3;
    localparam int SLOTO_W  = 5;
    localparam int LEN_W    = 24;
    localparam int SEQ_W    = 32;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 24'd4194304;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JOIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BIG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_JOINED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FRAME  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd5;

    typedef struct packed {
        logic load;
        logic wr_zero;
        logic wr_big;
        logic wr_store;
        logic bad;
        logic join_start;
        logic ovr_start;
        logic rd_start;
        logic jw_step;
        logic jw_finish;
        logic rw_step;
        logic rw_none;
        logic rw_hit;
        logic len_done;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_join;
        logic is_bad;
        logic zero;
        logic oversize;
        logic overrun;
        logic jw_done;
        logic rw_empty;
        logic rw_skip;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> sv/kfr_if.sv
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface kfr_req_if;
    logic                          valid;
    logic                          ready;
    logic [kfr_pkg::MODE_W-1:0]    mode;
    logic [kfr_pkg::BYTES_W-1:0]   frame_bytes;
    logic                          is_key;
    logic [kfr_pkg::VIEWER_W-1:0]  viewer;
    modport source (output valid, mode, frame_bytes, is_key, viewer, input ready);
    modport sink   (input valid, mode, frame_bytes, is_key, viewer, output ready);
endinterface

interface kfr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [kfr_pkg::STATUS_W-1:0]  status;
    logic [kfr_pkg::SLOTO_W-1:0]   slot;
    logic [kfr_pkg::LEN_W-1:0]     send_bytes;
    logic [kfr_pkg::SEQ_W-1:0]     sequence_res;
    logic [kfr_pkg::SEQ_W-1:0]     dropped;
    modport source (output valid, status, slot, send_bytes, sequence_res, dropped,
                    input ready);
    modport sink   (input valid, status, slot, send_bytes, sequence_res, dropped,
                    output ready);
endinterface

interface kfr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [kfr_pkg::LEN_W-1:0]   max_frame_bytes;
    modport source (output valid, max_frame_bytes, input ready);
    modport sink   (input valid, max_frame_bytes, output ready);
endinterface
`default_nettype wire

>>> sv/kfr_ctrl.sv
// Controller state machine sequencing writes, joins and reads.
`timescale 1ns / 1ps
`default_nettype none
module kfr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire kfr_pkg::sts_t sts,
    output kfr_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_JWALK,
        S_RWALK,
        S_LEN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.is_write)
                begin
                    if (sts.zero)
                        cmd.wr_zero = 1'b1;
                    else if (sts.oversize)
                        cmd.wr_big = 1'b1;
                    else
                        cmd.wr_store = 1'b1;
                    state_next = S_FINISH;
                end
                else if (sts.is_bad)
                begin
                    cmd.bad    = 1'b1;
                    state_next = S_FINISH;
                end
                else if (sts.is_join)
                begin
                    cmd.join_start = 1'b1;
                    state_next     = S_JWALK;
                end
                else if (sts.overrun)
                begin
                    cmd.ovr_start = 1'b1;
                    state_next    = S_JWALK;
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_RWALK;
                end
            end
            S_JWALK:
            begin
                if (sts.jw_done)
                begin
                    cmd.jw_finish = 1'b1;
                    state_next    = sts.is_join ? S_FINISH : S_RWALK;
                end
                else
                    cmd.jw_step = 1'b1;
            end
            S_RWALK:
            begin
                if (sts.rw_empty)
                begin
                    cmd.rw_none = 1'b1;
                    state_next  = S_FINISH;
                end
                else if (sts.rw_skip)
                    cmd.rw_step = 1'b1;
                else
                begin
                    cmd.rw_hit = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.len_done = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> sv/kfr_dpath.sv
// Datapath: ring state, viewer tail memory, walk counters and output register.
`timescale 1ns / 1ps
`default_nettype none
module kfr_dpath #(
    parameter int SLOTS   = kfr_pkg::SLOTS_DEFAULT,
    parameter int VIEWERS = kfr_pkg::VIEWERS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kfr_pkg::cmd_t                 cmd,
    output kfr_pkg::sts_t                      sts,
    input  wire logic [kfr_pkg::MODE_W-1:0]    req_mode,
    input  wire logic [kfr_pkg::BYTES_W-1:0]   req_frame_bytes,
    input  wire logic                          req_is_key,
    input  wire logic [kfr_pkg::VIEWER_W-1:0]  req_viewer,
    input  wire logic                          cfg_valid,
    input  wire logic [kfr_pkg::LEN_W-1:0]     cfg_data,
    input  wire logic                          rsp_ready,
    output logic                               rsp_valid,
    output logic [kfr_pkg::STATUS_W-1:0]       rsp_status,
    output logic [kfr_pkg::SLOTO_W-1:0]        rsp_slot,
    output logic [kfr_pkg::LEN_W-1:0]          rsp_send_bytes,
    output logic [kfr_pkg::SEQ_W-1:0]          rsp_sequence_res,
    output logic [kfr_pkg::SEQ_W-1:0]          rsp_dropped
);

    localparam int SW = $clog2(SLOTS);
    localparam int RW = $clog2(SLOTS + 1);
    localparam int VW = (VIEWERS > 1) ? $clog2(VIEWERS) : 1;
    localparam int QW = kfr_pkg::SEQ_W;
    localparam longint unsigned WRAP_SLOT_L = 64'hFFFF_FFFF % SLOTS;
    localparam logic [SW-1:0] WRAP_SLOT = SW'(WRAP_SLOT_L);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef struct packed {
        logic [QW-1:0] tail;
        logic [SW-1:0] slot;
    } tent_t;

    // slot of cnt+1 and cnt-1, with the 2^32 counter wrap
    function automatic logic [SW-1:0] slot_inc(input logic [QW-1:0] cnt,
                                               input logic [SW-1:0] s);
        if (cnt == '1 || s == LAST_SLOT)
            return '0;
        return s + SW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [QW-1:0] cnt,
                                               input logic [SW-1:0] s);
        if (cnt == '0)
            return WRAP_SLOT;
        if (s == '0)
            return LAST_SLOT;
        return s - SW'(1);
    endfunction

    logic [kfr_pkg::LEN_W-1:0]    max_reg;
    logic [QW-1:0]                head_reg;
    logic [SW-1:0]                hslot_reg;
    logic [SLOTS-1:0]             key_reg;
    logic [VIEWERS-1:0]           tvalid_reg;
    logic [VIEWERS-1:0]           need_reg;
    logic                         out_valid_reg;

    logic [kfr_pkg::MODE_W-1:0]   mode_reg;
    logic [kfr_pkg::BYTES_W-1:0]  bytes_reg;
    logic                         key_in_reg;
    logic [kfr_pkg::VIEWER_W-1:0] viewer_reg;

    logic [kfr_pkg::LEN_W-1:0]    lmem [SLOTS];
    logic [kfr_pkg::LEN_W-1:0]    lrd_reg;
    tent_t                        tmem [VIEWERS];
    tent_t                        trd_reg;
    logic                         trd_valid_reg;

    logic [QW-1:0]                t_reg;
    logic [SW-1:0]                tslot_reg;
    logic [QW-1:0]                c_reg;
    logic [SW-1:0]                cslot_reg;
    logic [RW-1:0]                rem_reg;
    logic [QW-1:0]                drop_reg;

    logic [kfr_pkg::STATUS_W-1:0] res_status_reg;
    logic [SW-1:0]                res_slot_reg;
    logic [kfr_pkg::LEN_W-1:0]    res_len_reg;
    logic [QW-1:0]                res_seq_reg;

    logic [kfr_pkg::STATUS_W-1:0] out_status_reg;
    logic [kfr_pkg::SLOTO_W-1:0]  out_slot_reg;
    logic [kfr_pkg::LEN_W-1:0]    out_len_reg;
    logic [QW-1:0]                out_seq_reg;
    logic [QW-1:0]                out_drop_reg;

    logic [VW-1:0]                vidx;
    tent_t                        trd;
    logic [QW-1:0]                behind;
    logic                         jw_found;
    tent_t                        jres;
    logic                         tw_en;
    tent_t                        tw_data;

    assign vidx   = VW'(viewer_reg);
    assign trd    = trd_valid_reg ? trd_reg : '0;
    assign behind = head_reg - trd.tail;

    assign jw_found  = (rem_reg != '0) && key_reg[cslot_reg];
    assign jres.tail = jw_found ? c_reg : head_reg;
    assign jres.slot = jw_found ? cslot_reg : hslot_reg;

    always_comb
    begin
        sts.is_write = (mode_reg == kfr_pkg::MODE_WRITE);
        sts.is_join  = (mode_reg == kfr_pkg::MODE_JOIN);
        sts.is_bad   = (mode_reg == kfr_pkg::MODE_NONE) ||
                       (32'(viewer_reg) >= 32'(VIEWERS));
        sts.zero     = (bytes_reg == '0);
        sts.oversize = (bytes_reg > {8'd0, max_reg});
        sts.overrun  = (behind >= 32'(SLOTS));
        sts.jw_done  = (rem_reg == '0) || key_reg[cslot_reg];
        sts.rw_empty = (t_reg == head_reg);
        sts.rw_skip  = need_reg[vidx] && !key_reg[tslot_reg];
        sts.out_free = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        tw_en   = 1'b0;
        tw_data = '0;
        if (cmd.jw_finish && sts.is_join)
        begin
            tw_en   = 1'b1;
            tw_data = jres;
        end
        else if (cmd.rw_none)
        begin
            tw_en        = 1'b1;
            tw_data.tail = t_reg;
            tw_data.slot = tslot_reg;
        end
        else if (cmd.rw_hit)
        begin
            tw_en        = 1'b1;
            tw_data.tail = t_reg + 32'd1;
            tw_data.slot = slot_inc(t_reg, tslot_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= kfr_pkg::MAX_FRAME_RESET;
            head_reg      <= '0;
            hslot_reg     <= '0;
            key_reg       <= '0;
            tvalid_reg    <= '0;
            need_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_reg <= cfg_data;
            if (cmd.wr_store)
            begin
                key_reg[hslot_reg] <= key_in_reg;
                head_reg           <= head_reg + 32'd1;
                hslot_reg          <= slot_inc(head_reg, hslot_reg);
            end
            if (tw_en)
                tvalid_reg[vidx] <= 1'b1;
            if (cmd.jw_finish)
                need_reg[vidx] <= !jw_found;
            else if (cmd.rw_hit)
                need_reg[vidx] <= 1'b0;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_store)
            lmem[hslot_reg] <= bytes_reg[kfr_pkg::LEN_W-1:0];
        if (cmd.rw_hit)
            lrd_reg <= lmem[tslot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
            tmem[vidx] <= tw_data;
        if (cmd.load)
        begin
            trd_reg       <= tmem[VW'(req_viewer)];
            trd_valid_reg <= tvalid_reg[VW'(req_viewer)];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= req_mode;
            bytes_reg    <= req_frame_bytes;
            key_in_reg   <= req_is_key;
            viewer_reg   <= req_viewer;
            drop_reg     <= '0;
            res_slot_reg <= '0;
            res_len_reg  <= '0;
            res_seq_reg  <= '0;
        end
        if (cmd.wr_zero)
            res_status_reg <= kfr_pkg::ST_ZERO;
        if (cmd.wr_big)
            res_status_reg <= kfr_pkg::ST_BIG;
        if (cmd.bad)
            res_status_reg <= kfr_pkg::ST_NONE;
        if (cmd.wr_store)
        begin
            res_status_reg <= kfr_pkg::ST_STORED;
            res_slot_reg   <= hslot_reg;
            res_seq_reg    <= head_reg;
        end
        if (cmd.join_start || cmd.ovr_start)
        begin
            c_reg     <= head_reg - 32'd1;
            cslot_reg <= slot_dec(head_reg, hslot_reg);
            rem_reg   <= (head_reg < 32'(SLOTS)) ? RW'(head_reg) : RW'(SLOTS);
        end
        if (cmd.ovr_start)
            drop_reg <= behind;
        if (cmd.rd_start)
        begin
            t_reg     <= trd.tail;
            tslot_reg <= trd.slot;
        end
        if (cmd.jw_step)
        begin
            c_reg     <= c_reg - 32'd1;
            cslot_reg <= slot_dec(c_reg, cslot_reg);
            rem_reg   <= rem_reg - RW'(1);
        end
        if (cmd.jw_finish)
        begin
            t_reg     <= jres.tail;
            tslot_reg <= jres.slot;
            if (sts.is_join)
            begin
                res_status_reg <= kfr_pkg::ST_JOINED;
                res_seq_reg    <= jres.tail;
            end
        end
        if (cmd.rw_step)
        begin
            t_reg     <= t_reg + 32'd1;
            tslot_reg <= slot_inc(t_reg, tslot_reg);
        end
        if (cmd.rw_none)
            res_status_reg <= kfr_pkg::ST_NONE;
        if (cmd.rw_hit)
        begin
            res_status_reg <= kfr_pkg::ST_FRAME;
            res_slot_reg   <= tslot_reg;
            res_seq_reg    <= t_reg;
        end
        if (cmd.len_done)
            res_len_reg <= lrd_reg;
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= kfr_pkg::SLOTO_W'(res_slot_reg);
            out_len_reg    <= res_len_reg;
            out_seq_reg    <= res_seq_reg;
            out_drop_reg   <= drop_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_slot         = out_slot_reg;
    assign rsp_send_bytes   = out_len_reg;
    assign rsp_sequence_res = out_seq_reg;
    assign rsp_dropped      = out_drop_reg;

endmodule
`default_nettype wire

>>> sv/keyframe_frame_ring_reader.sv
// Accept to response valid: a write, rejected or bad beat passes dispatch and finish.
// A join walks back over the ring, one ring slot per cycle in the key-frame walk.
// A read takes a forward walk, or a resync walk followed by one send.
// One item in flight; the next beat is accepted the cycle after the response loads,
// so a new beat waits for the last response to load; a held response stalls the next.
// Reset: async active low; head, tails, key marks zero, need-key set, lengths undefined.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_frame_ring_reader #(
    parameter int SLOTS   = kfr_pkg::SLOTS_DEFAULT,
    parameter int VIEWERS = kfr_pkg::VIEWERS_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kfr_req_if.sink    req,
    kfr_rsp_if.source  rsp,
    kfr_cfg_if.sink    cfg
);

    kfr_pkg::cmd_t cmd;
    kfr_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    kfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kfr_dpath #(
        .SLOTS   (SLOTS),
        .VIEWERS (VIEWERS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_mode         (req.mode),
        .req_frame_bytes  (req.frame_bytes),
        .req_is_key       (req.is_key),
        .req_viewer       (req.viewer),
        .cfg_valid        (cfg.valid),
        .cfg_data         (cfg.max_frame_bytes),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_status       (rsp.status),
        .rsp_slot         (rsp.slot),
        .rsp_send_bytes   (rsp.send_bytes),
        .rsp_sequence_res (rsp.sequence_res),
        .rsp_dropped      (rsp.dropped)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted on back-to-back cycles");

    a_len_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != kfr_pkg::ST_FRAME) |-> rsp.send_bytes == '0)
        else $error("send_bytes nonzero without a frame to send");

    a_drop_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.dropped != '0) |->
            (rsp.status == kfr_pkg::ST_FRAME) || (rsp.status == kfr_pkg::ST_NONE))
        else $error("drop count on a non-read response");

    a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == kfr_pkg::ST_NONE) |->
            (rsp.slot == '0) && (rsp.sequence_res == '0))
        else $error("nothing-ready response carries a slot or sequence");

endmodule
`default_nettype wire
